@@ design/bfgr_pkg.sv @@
`default_nettype none

package bfgr_pkg;

  localparam logic [1:0] CMD_LOAD_ROW = 2'd0;
  localparam logic [1:0] CMD_LOAD_ADV = 2'd1;
  localparam logic [1:0] CMD_DRAW     = 2'd2;

  localparam logic [2:0] REG_FIRST_CHAR   = 3'd0;
  localparam logic [2:0] REG_NUM_CHARS    = 3'd1;
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CHAR_GAP     = 3'd4;
  localparam logic [2:0] REG_INK_COLOR    = 3'd5;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd6;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd7;

  localparam int CFG_DATA_W = 9;
  localparam int PEN_W      = 12;
  localparam logic [PEN_W-1:0] PEN_MAX = 12'hFFF;
  localparam int FB_ADDR_W  = 17;
  localparam int WORD_W     = 32;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic [7:0]  advance;
    logic        text_start;
    logic        text_end;
  } in_t;

  typedef struct packed {
    logic [16:0] fb_address;
    logic [31:0] pixel_mask;
    logic [7:0]  color;
    logic        last_row;
  } out_t;

endpackage

`default_nettype wire

@@ design/bfgr_ram.sv @@
`default_nettype none

module bfgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/bitmap_font_glyph_renderer.sv @@
`default_nettype none
// Channel  Direction  Transaction
// in_      input      load glyph row, load advance or draw one character
// out_     output     one glyph row: framebuffer address, pixel mask, color, last flag
// cfg_     input      register write, no read-back
//
// A draw emits H = min(glyph_height, MAX_ROWS) rows, or none outside the font; the
// glyph row memory delivers one row per cycle while the output is not stalled.
// in_stall is high while a draw is in progress; a held output row adds stall cycles.
// The output register lets the next transaction in while the last row waits.
// Reset clears the advance-table valid flags at once; there is no clearing pass.

module bitmap_font_glyph_renderer
  import bfgr_pkg::*;
#(
  parameter int MAX_ROWS    = 22,
  parameter int MAX_COLUMNS = 32,
  parameter int LINE_PITCH  = 320,
  parameter int CHAR_CODES  = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int GA_W    = $clog2(CHAR_CODES * MAX_ROWS);
  localparam int CA_W    = $clog2(CHAR_CODES);
  localparam int RC_W    = ($clog2(MAX_ROWS + 1) > 5) ? $clog2(MAX_ROWS + 1) : 5;
  localparam int COL_LIM = (MAX_COLUMNS < WORD_W) ? MAX_COLUMNS : WORD_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROWS = 3'b010,
    ST_ADV  = 3'b100
  } state_t;

  logic [7:0] first_char_r;
  logic [8:0] num_chars_r;
  logic [5:0] glyph_width_r;
  logic [4:0] glyph_height_r;
  logic [3:0] char_gap_r;
  logic [7:0] ink_color_r;
  logic [8:0] origin_x_r;
  logic [7:0] origin_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_char_r   <= 8'd32;
      num_chars_r    <= 9'd0;
      glyph_width_r  <= 6'd0;
      glyph_height_r <= 5'd0;
      char_gap_r     <= 4'd1;
      ink_color_r    <= 8'd15;
      origin_x_r     <= 9'd0;
      origin_y_r     <= 8'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIRST_CHAR:   first_char_r   <= cfg_wdata[7:0];
        REG_NUM_CHARS:    num_chars_r    <= cfg_wdata[8:0];
        REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_wdata[5:0];
        REG_GLYPH_HEIGHT: glyph_height_r <= cfg_wdata[4:0];
        REG_CHAR_GAP:     char_gap_r     <= cfg_wdata[3:0];
        REG_INK_COLOR:    ink_color_r    <= cfg_wdata[7:0];
        REG_ORIGIN_X:     origin_x_r     <= cfg_wdata[8:0];
        REG_ORIGIN_Y:     origin_y_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  state_t            state_r, state_nxt;
  logic [GA_W-1:0]   base_r;
  logic [RC_W-1:0]   row_r;
  logic [RC_W-1:0]   h_r;
  logic              end_r;
  logic              adv_ok_r;
  logic [PEN_W-1:0]  pen_r;
  logic [CHAR_CODES-1:0] adv_vld_r;
  logic              out_valid_r;
  out_t              out_data_r;

  logic              in_acc;
  logic              code_ok;
  logic              row_ok;
  logic              in_font;
  logic [CA_W-1:0]   code_idx;
  logic [GA_W-1:0]   code_base;
  logic [RC_W-1:0]   h_cur;
  logic              is_draw;

  logic              glyph_we;
  logic [GA_W-1:0]   glyph_wr_addr;
  logic              glyph_re;
  logic [GA_W-1:0]   glyph_rd_addr;
  logic [WORD_W-1:0] glyph_rdata;
  logic              adv_we;
  logic              adv_re;
  logic [7:0]        adv_rdata;

  logic              out_free;
  logic              emit;
  logic              last;
  logic              pen_upd;
  logic [PEN_W:0]    pen_sum;
  logic [PEN_W-1:0]  pen_nxt;
  logic [7:0]        adv_eff;
  logic [3:0]        gap_eff;
  logic [31:0]       addr_wide;
  logic [WORD_W-1:0] word_rev;
  logic [5:0]        col;
  logic [WORD_W-1:0] col_mask;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_draw  = in_acc && (in_data.cmd == CMD_DRAW);

  assign code_idx  = in_data.char_code[CA_W-1:0];
  assign code_ok   = {1'b0, in_data.char_code} < 9'(CHAR_CODES);
  assign row_ok    = 7'(in_data.row_index) < 7'(MAX_ROWS);
  assign in_font   = (in_data.char_code >= first_char_r) &&
                     (({1'b0, in_data.char_code} - {1'b0, first_char_r}) < num_chars_r) &&
                     code_ok;
  assign code_base = GA_W'(in_data.char_code) * GA_W'(MAX_ROWS);
  assign h_cur     = (RC_W'(glyph_height_r) < RC_W'(MAX_ROWS)) ?
                     RC_W'(glyph_height_r) : RC_W'(MAX_ROWS);

  assign glyph_we      = in_acc && (in_data.cmd == CMD_LOAD_ROW) && code_ok && row_ok;
  assign glyph_wr_addr = code_base + GA_W'(in_data.row_index);
  assign adv_we        = in_acc && (in_data.cmd == CMD_LOAD_ADV) && code_ok;
  assign adv_re        = is_draw;

  bfgr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHAR_CODES * MAX_ROWS)
  ) u_glyph_ram (
    .clk     (clk),
    .wr_en   (glyph_we),
    .wr_addr (glyph_wr_addr),
    .wr_data (in_data.row_bits),
    .rd_en   (glyph_re),
    .rd_addr (glyph_rd_addr),
    .rd_data (glyph_rdata)
  );

  bfgr_ram #(
    .WIDTH (8),
    .DEPTH (CHAR_CODES)
  ) u_adv_ram (
    .clk     (clk),
    .wr_en   (adv_we),
    .wr_addr (code_idx),
    .wr_data (in_data.advance),
    .rd_en   (adv_re),
    .rd_addr (code_idx),
    .rd_data (adv_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign last     = ((row_r + 1'b1) == h_r);

  always_comb begin
    state_nxt     = state_r;
    emit          = 1'b0;
    pen_upd       = 1'b0;
    glyph_re      = 1'b0;
    glyph_rd_addr = code_base;
    unique case (state_r)
      ST_IDLE: begin
        if (is_draw) begin
          glyph_re  = 1'b1;
          state_nxt = (in_font && (h_cur != '0)) ? ST_ROWS : ST_ADV;
        end
      end
      ST_ROWS: begin
        if (out_free) begin
          emit = 1'b1;
          if (last) begin
            pen_upd   = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            glyph_re      = 1'b1;
            glyph_rd_addr = base_r + GA_W'(row_r + 1'b1);
          end
        end
      end
      ST_ADV: begin
        pen_upd   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign adv_eff = adv_ok_r ? adv_rdata : 8'd0;
  assign gap_eff = end_r ? 4'd0 : char_gap_r;
  assign pen_sum = (PEN_W + 1)'(pen_r) + (PEN_W + 1)'(adv_eff) + (PEN_W + 1)'(gap_eff);
  assign pen_nxt = (pen_sum > (PEN_W + 1)'(PEN_MAX)) ? PEN_MAX : pen_sum[PEN_W-1:0];

  assign addr_wide = (32'(origin_y_r) + 32'(row_r)) * 32'(LINE_PITCH) + 32'(pen_r);
  assign col       = (glyph_width_r < 6'(COL_LIM)) ? glyph_width_r : 6'(COL_LIM);
  assign col_mask  = WORD_W'((33'd1 << col) - 33'd1);

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      word_rev[i] = glyph_rdata[WORD_W-1-i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pen_r     <= '0;
      adv_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (is_draw && in_data.text_start) begin
        pen_r <= PEN_W'(origin_x_r);
      end else if (pen_upd) begin
        pen_r <= pen_nxt;
      end
      if (adv_we) begin
        adv_vld_r[code_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_draw) begin
      base_r   <= code_base;
      row_r    <= '0;
      h_r      <= h_cur;
      end_r    <= in_data.text_end;
      adv_ok_r <= code_ok && adv_vld_r[code_idx];
    end else if (emit) begin
      row_r <= row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.fb_address <= addr_wide[FB_ADDR_W-1:0];
      out_data_r.pixel_mask <= word_rev & col_mask;
      out_data_r.color      <= ink_color_r;
      out_data_r.last_row   <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ design/bfgr_checker.sv @@
`default_nettype none

module bfgr_checker
  import bfgr_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire in_t  in_data,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // more rows of the character remain, so no new transaction may enter
  a_rows_block_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_row |-> in_stall)
    else $error("input open before the last row");

  // a draw only starts from an accepted draw transaction
  a_stall_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid) && ($past(in_data.cmd) == CMD_DRAW))
    else $error("stall rose without an accepted draw");

endmodule

bind bitmap_font_glyph_renderer bfgr_checker u_bfgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ bench/bitmap_font_glyph_renderer_checker.sv @@
`timescale 1ns / 100ps

module bitmap_font_glyph_renderer_checker
  import bfgr_pkg::*;
#(
  parameter int MAX_ROWS    = 22,
  parameter int MAX_COLUMNS = 32,
  parameter int LINE_PITCH  = 320,
  parameter int CHAR_CODES  = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_t                  out_data,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  logic [WORD_W-1:0] glyph_rows [CHAR_CODES*MAX_ROWS];
  logic [7:0]        advances [CHAR_CODES];
  logic [PEN_W-1:0]  pen;
  logic [7:0]        first_char, ink_color, origin_y;
  logic [8:0]        num_chars, origin_x;
  logic [5:0]        glyph_width;
  logic [4:0]        glyph_height;
  logic [3:0]        char_gap;
  out_t              rows_due [$];
  int                mismatches = 0;

  task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    mismatches++;
  endtask

  function automatic void render_char(input in_t t);
    int rows, cols, code, y, i, step;
    logic [WORD_W-1:0] word;
    out_t row_out;
    code = int'(t.char_code);
    if (t.text_start) pen = PEN_W'(origin_x);
    rows = (int'(glyph_height) < MAX_ROWS) ? int'(glyph_height) : MAX_ROWS;
    cols = int'(glyph_width);
    if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
    if (cols > WORD_W) cols = WORD_W;
    if (code >= int'(first_char) && code - int'(first_char) < int'(num_chars)
        && code < CHAR_CODES) begin
      for (y = 0; y < rows; y++) begin
        word = glyph_rows[code*MAX_ROWS + y];
        row_out.fb_address = FB_ADDR_W'((int'(origin_y) + y) * LINE_PITCH + int'(pen));
        row_out.pixel_mask = '0;
        // leftmost column sits in the word's top bit
        for (i = 0; i < cols; i++) row_out.pixel_mask[i] = word[WORD_W-1-i];
        row_out.color = ink_color;
        row_out.last_row = (y == rows - 1);
        rows_due.push_back(row_out);
      end
    end
    step = int'(pen) + int'(advances[code]) + (t.text_end ? 0 : int'(char_gap));
    pen = (step > int'(PEN_MAX)) ? PEN_MAX : PEN_W'(step);
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      foreach (advances[k]) advances[k] = '0;
      pen          = '0;
      first_char   = 8'd32;
      num_chars    = '0;
      glyph_width  = '0;
      glyph_height = '0;
      char_gap     = 4'd1;
      ink_color    = 8'd15;
      origin_x     = '0;
      origin_y     = '0;
      rows_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (rows_due.size() == 0) begin
          $display("%0t: row expected none actual %0h", $time, out_data);
          mismatches++;
        end else begin
          want = rows_due.pop_front();
          if (out_data.fb_address !== want.fb_address)
            flag("fb_address", 32'(want.fb_address), 32'(out_data.fb_address));
          if (out_data.pixel_mask !== want.pixel_mask)
            flag("pixel_mask", want.pixel_mask, out_data.pixel_mask);
          if (out_data.color !== want.color)
            flag("color", 32'(want.color), 32'(out_data.color));
          if (out_data.last_row !== want.last_row)
            flag("last_row", 32'(want.last_row), 32'(out_data.last_row));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FIRST_CHAR:   first_char   = cfg_wdata[7:0];
          REG_NUM_CHARS:    num_chars    = cfg_wdata[8:0];
          REG_GLYPH_WIDTH:  glyph_width  = cfg_wdata[5:0];
          REG_GLYPH_HEIGHT: glyph_height = cfg_wdata[4:0];
          REG_CHAR_GAP:     char_gap     = cfg_wdata[3:0];
          REG_INK_COLOR:    ink_color    = cfg_wdata[7:0];
          REG_ORIGIN_X:     origin_x     = cfg_wdata[8:0];
          REG_ORIGIN_Y:     origin_y     = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_data.cmd)
          CMD_LOAD_ROW: begin
            if (int'(in_data.row_index) < MAX_ROWS)
              glyph_rows[int'(in_data.char_code)*MAX_ROWS + int'(in_data.row_index)] =
                in_data.row_bits;
          end
          CMD_LOAD_ADV: advances[in_data.char_code] = in_data.advance;
          CMD_DRAW:     render_char(in_data);
          default: ;
        endcase
      end
    end
    errors  <= mismatches;
    pending <= rows_due.size();
  end

endmodule

@@ bench/bitmap_font_glyph_renderer_tb.sv @@
`timescale 1ns / 100ps

module bitmap_font_glyph_renderer_tb;
  import bfgr_pkg::*;

  localparam int MAX_ROWS       = 22;
  localparam int CHAR_CODES     = 256;
  localparam int ITEM_TARGET    = 330;
  localparam int PHASE_ITEMS    = 45;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_t                   in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall, out_valid;
  out_t                  out_data;
  int                    errors, pending;

  int idle_cycles = 0;
  int stall_run   = 0;
  int burst_left  = 0;
  int items_sent  = 0;
  int cur_first   = 32;
  int cur_num     = 0;
  int cur_height  = 0;
  bit row_loaded [CHAR_CODES][MAX_ROWS];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bitmap_font_glyph_renderer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bitmap_font_glyph_renderer_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("bitmap_font_glyph_renderer_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 99) < 35) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 23);
    end
  end

  function automatic in_t random_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return in_t'(raw[$bits(in_t)-1:0]);
  endfunction

  task automatic send(input in_t t);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (t.cmd == CMD_LOAD_ROW && int'(t.row_index) < MAX_ROWS)
      row_loaded[t.char_code][t.row_index] = 1'b1;
    if (t.cmd != CMD_UNUSED && !(t.cmd == CMD_LOAD_ROW && int'(t.row_index) >= MAX_ROWS))
      items_sent++;
  endtask

  task automatic load_row(input int code, input int row, input logic [31:0] bits);
    in_t t;
    t = random_item();
    t.cmd       = CMD_LOAD_ROW;
    t.char_code = code[7:0];
    t.row_index = row[4:0];
    t.row_bits  = bits;
    send(t);
  endtask

  task automatic load_adv(input int code, input int adv);
    in_t t;
    t = random_item();
    t.cmd       = CMD_LOAD_ADV;
    t.char_code = code[7:0];
    t.advance   = adv[7:0];
    send(t);
  endtask

  task automatic send_unused();
    in_t t;
    t = random_item();
    t.cmd = CMD_UNUSED;
    send(t);
  endtask

  // glyph rows of a character in the font must be loaded before it is drawn
  task automatic draw(input int code, input bit starts, input bit ends);
    in_t t;
    int  rows;
    rows = (cur_height < MAX_ROWS) ? cur_height : MAX_ROWS;
    if (code >= cur_first && code - cur_first < cur_num) begin
      for (int r = 0; r < rows; r++)
        if (!row_loaded[code][r]) load_row(code, r, $urandom());
    end
    t = random_item();
    t.cmd        = CMD_DRAW;
    t.char_code  = code[7:0];
    t.text_start = starts;
    t.text_end   = ends;
    send(t);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic configure(input int fc, input int nc, input int gw, input int gh,
                           input int gap_px, input int ink, input int ox, input int oy);
    quiesce();
    write_reg(REG_FIRST_CHAR, fc);
    write_reg(REG_NUM_CHARS, nc);
    write_reg(REG_GLYPH_WIDTH, gw);
    write_reg(REG_GLYPH_HEIGHT, gh);
    write_reg(REG_CHAR_GAP, gap_px);
    write_reg(REG_INK_COLOR, ink);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    cfg_wr_en  <= 1'b0;
    cur_first  = fc;
    cur_num    = nc;
    cur_height = gh;
  endtask

  function automatic int pick_code();
    int span;
    span = CHAR_CODES - cur_first;
    if (cur_num < span) span = cur_num;
    if (span > 0 && $urandom_range(0, 99) < 85) return cur_first + $urandom_range(0, span - 1);
    return $urandom_range(0, CHAR_CODES - 1);
  endfunction

  task automatic random_config();
    int nc, gh;
    case ($urandom_range(0, 3))
      0:       nc = $urandom_range(1, 8);
      1:       nc = $urandom_range(0, 40);
      2:       nc = CHAR_CODES;
      default: nc = $urandom_range(0, 511);
    endcase
    gh = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(0, 31);
    configure($urandom_range(0, 255), nc, $urandom_range(0, 63), gh,
              $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 511),
              $urandom_range(0, 255));
  endtask

  task automatic random_phase(input int count);
    int goal, len, sel;
    bit starts, ends;
    goal = items_sent + count;
    while (items_sent < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        // one text: start on the first character, end on the last, sometimes broken
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          starts = (k == 0);
          ends   = (k == len - 1);
          if ($urandom_range(0, 9) == 0) starts = 1'($urandom());
          if ($urandom_range(0, 9) == 0) ends = 1'($urandom());
          draw(pick_code(), starts, ends);
        end
      end else if (sel < 77) begin
        load_adv(pick_code(), $urandom_range(0, 255));
      end else if (sel < 87) begin
        load_row($urandom_range(0, 255), $urandom_range(0, 31), $urandom());
      end else if (sel < 92) begin
        send_unused();
      end else begin
        draw($urandom_range(0, 255), 1'($urandom()), 1'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset font is empty: draws only move the pen
    load_adv(0, 255);
    load_adv(255, 170);
    send_unused();
    draw(65, 1'b1, 1'b0);
    draw(0, 1'b0, 1'b1);

    configure(1, 255, 32, 3, 0, 0, 319, 0);
    load_row(255, 0, 32'h0000_0000);
    load_row(255, 1, 32'hFFFF_FFFF);
    load_row(255, 2, 32'h8000_0001);
    load_row(255, 31, 32'hFFFF_0000);
    draw(255, 1'b1, 1'b0);
    draw(1, 1'b0, 1'b0);
    draw(0, 1'b0, 1'b1);
    draw(255, 1'b1, 1'b1);

    // oversized cell, one-character font at the top code
    configure(255, 1, 63, 31, 15, 255, 0, 255);
    draw(255, 1'b1, 1'b0);
    draw(254, 1'b0, 1'b0);
    draw(255, 1'b0, 1'b1);

    // zero-size cell, pen runs into saturation
    configure(0, 511, 0, 0, 15, 1, 511, 128);
    for (int k = 0; k < 16; k++) draw(0, k == 0, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      random_config();
      random_phase(PHASE_ITEMS);
    end

    quiesce();
    if (errors == 0 && pending == 0) begin
      $display("bitmap_font_glyph_renderer_tb: clean");
    end else begin
      $display("bitmap_font_glyph_renderer_tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/bfgr_pkg.sv
design/bfgr_ram.sv
design/bitmap_font_glyph_renderer.sv
design/bfgr_checker.sv
bench/bitmap_font_glyph_renderer_checker.sv
bench/bitmap_font_glyph_renderer_tb.sv
